### rtl/ncc_pkg.sv
// Shared constants, codes and types of the normalized cross-correlation block.
// Depends on nothing; every other file but ncc_ram refers to it by scoped names.
`default_nettype none
package ncc_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int MAX_LAGS_DEF    = 31;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int LAG_W     = 6;
  localparam int COEF_W    = 32;
  localparam int LAGS_W    = 5;
  localparam int ACC_W     = 64;
  localparam int WIDE_W    = 128;
  localparam int Q_W       = 40;
  localparam int ROOT_W    = 64;
  localparam int SQ_REM_W  = 68;
  localparam int STEP_W    = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LAGS_W-1:0] LAG_BOUND_RESET = 5'd16;
  // Register index sits in address bit 2 (byte address 4*i)
  localparam logic REG_LAG_BOUND = 1'b0;

  // Number of leading quotient bits that only flag overflow
  localparam logic [STEP_W-1:0] DIV_Q_START = 7'd88;
  localparam logic [STEP_W-1:0] DIV_LAST    = 7'd127;
  localparam logic [STEP_W-1:0] SQRT_LAST   = 7'd63;
  localparam int P_SHIFT   = 24;
  localparam int NUM_SHIFT = 28;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_SQRT = 2'd1,
    OP_DIV  = 2'd2
  } ncc_op_t;

  typedef struct packed {
    logic    start;
    ncc_op_t op;
  } ncc_arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ncc_arith_stat_t;

  typedef enum logic [4:0] {
    S_LOAD    = 5'd0,
    S_EN_RD   = 5'd1,
    S_EN_WAIT = 5'd2,
    S_PMUL_GO = 5'd3,
    S_PMUL_WT = 5'd4,
    S_SQRT_GO = 5'd5,
    S_SQRT_WT = 5'd6,
    S_LAG     = 5'd7,
    S_CR_RD   = 5'd8,
    S_CR_WAIT = 5'd9,
    S_NUM_GO  = 5'd10,
    S_NUM_WT  = 5'd11,
    S_DEN_GO  = 5'd12,
    S_DEN_WT  = 5'd13,
    S_DIV_GO  = 5'd14,
    S_DIV_WT  = 5'd15,
    S_EMIT    = 5'd16
  } ncc_state_t;

endpackage
`default_nettype wire

### rtl/ncc_if.sv
// Valid/ready stream interfaces for sample pairs in and coefficients out.
// Depends on ncc_pkg for widths and defaults.
`default_nettype none
interface ncc_in_if #(
  parameter int SAMPLE_BITS = ncc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] x_sample;
  logic signed [SAMPLE_BITS-1:0] y_sample;
  logic                          last_sample;

  modport source (output valid, x_sample, y_sample, last_sample, input ready);
  modport sink   (input valid, x_sample, y_sample, last_sample, output ready);
endinterface

interface ncc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ncc_pkg::LAG_W-1:0]  lag;
  logic signed [ncc_pkg::COEF_W-1:0] coefficient;
  logic                              last_result;

  modport source (output valid, lag, coefficient, last_result, input ready);
  modport sink   (input valid, lag, coefficient, last_result, output ready);
endinterface
`default_nettype wire

### rtl/ncc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none
module ncc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### rtl/ncc_mac.sv
// Two-lane multiply-accumulate: registered products, then 64-bit wrapping sums.
// Depends on ncc_pkg.
`default_nettype none
module ncc_mac #(
  parameter int SAMPLE_BITS = ncc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clr,
  input  wire logic                          vld,
  input  wire logic signed [SAMPLE_BITS-1:0] a0,
  input  wire logic signed [SAMPLE_BITS-1:0] b0,
  input  wire logic signed [SAMPLE_BITS-1:0] a1,
  input  wire logic signed [SAMPLE_BITS-1:0] b1,
  output      logic                          busy,
  output      logic [ncc_pkg::ACC_W-1:0]     sum0,
  output      logic [ncc_pkg::ACC_W-1:0]     sum1
);
  logic signed [2*SAMPLE_BITS-1:0] p0_r, p1_r;
  logic                            v_r;
  logic [ncc_pkg::ACC_W-1:0]       sum0_r, sum1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    p0_r <= a0 * b0;
    p1_r <= a1 * b1;
    if (clr) begin
      sum0_r <= '0;
      sum1_r <= '0;
    end else if (v_r) begin
      sum0_r <= sum0_r + ncc_pkg::ACC_W'(p0_r);
      sum1_r <= sum1_r + ncc_pkg::ACC_W'(p1_r);
    end
  end

  assign busy = v_r;
  assign sum0 = sum0_r;
  assign sum1 = sum1_r;
endmodule
`default_nettype wire

### rtl/ncc_arith.sv
// Shared iterative arithmetic unit: shift-add multiply, bit-pair square root
// and restoring divide, one step a cycle. Depends on ncc_pkg.
`default_nettype none
module ncc_arith (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ncc_pkg::ncc_arith_req_t        req,
  input  wire logic [ncc_pkg::WIDE_W-1:0]     a,
  input  wire logic [ncc_pkg::ACC_W-1:0]      b,
  output      ncc_pkg::ncc_arith_stat_t       stat,
  output      logic [ncc_pkg::WIDE_W-1:0]     res,
  output      logic [ncc_pkg::ACC_W-1:0]      rem,
  output      logic                           big
);
  logic                          busy_r, done_r, big_r;
  ncc_pkg::ncc_op_t              op_r;
  logic [ncc_pkg::WIDE_W-1:0]    acc_r, opa_r;
  logic [ncc_pkg::ACC_W-1:0]     opb_r;
  logic [ncc_pkg::SQ_REM_W-1:0]  rem_r;
  logic [ncc_pkg::STEP_W-1:0]    cnt_r;

  // square root step
  logic [ncc_pkg::SQ_REM_W-1:0]  sq_cur, sq_trial;
  logic                          sq_ge;
  // divide step
  logic [ncc_pkg::ACC_W:0]       dv_sh;
  logic                          dv_ge;

  always_comb begin
    sq_cur   = {rem_r[ncc_pkg::SQ_REM_W-3:0], opa_r[ncc_pkg::WIDE_W-1 -: 2]};
    sq_trial = {2'b00, acc_r[ncc_pkg::ROOT_W-1:0], 2'b01};
    sq_ge    = sq_cur >= sq_trial;
    dv_sh    = {rem_r[ncc_pkg::ACC_W-1:0], opa_r[ncc_pkg::WIDE_W-1]};
    dv_ge    = dv_sh[ncc_pkg::ACC_W] || (dv_sh[ncc_pkg::ACC_W-1:0] >= opb_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        case (op_r)
          ncc_pkg::OP_MUL: begin
            if (opb_r == '0) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          ncc_pkg::OP_SQRT: begin
            if (cnt_r == ncc_pkg::SQRT_LAST) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: begin
            if (cnt_r == ncc_pkg::DIV_LAST) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      acc_r <= '0;
      opa_r <= a;
      opb_r <= b;
      rem_r <= '0;
      cnt_r <= '0;
      big_r <= 1'b0;
    end else if (busy_r) begin
      case (op_r)
        ncc_pkg::OP_MUL: begin
          if (opb_r[0]) begin
            acc_r <= acc_r + opa_r;
          end
          opa_r <= opa_r << 1;
          opb_r <= opb_r >> 1;
        end
        ncc_pkg::OP_SQRT: begin
          rem_r <= sq_ge ? (sq_cur - sq_trial) : sq_cur;
          acc_r <= {acc_r[ncc_pkg::WIDE_W-2:0], sq_ge};
          opa_r <= opa_r << 2;
          cnt_r <= cnt_r + 1'b1;
        end
        default: begin
          rem_r <= {{(ncc_pkg::SQ_REM_W-ncc_pkg::ACC_W){1'b0}},
                    dv_ge ? (dv_sh[ncc_pkg::ACC_W-1:0] - opb_r)
                          : dv_sh[ncc_pkg::ACC_W-1:0]};
          acc_r <= {acc_r[ncc_pkg::WIDE_W-2:0],
                    dv_ge && (cnt_r >= ncc_pkg::DIV_Q_START)};
          if (dv_ge && (cnt_r < ncc_pkg::DIV_Q_START)) begin
            big_r <= 1'b1;
          end
          opa_r <= opa_r << 1;
          cnt_r <= cnt_r + 1'b1;
        end
      endcase
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = acc_r;
  assign rem       = rem_r[ncc_pkg::ACC_W-1:0];
  assign big       = big_r;
endmodule
`default_nettype wire

### rtl/normalized_cross_correlation.sv
// Top level of the normalized unbiased cross-correlation block: sequencer,
// config register, sample RAMs. Depends on ncc_pkg, ncc_if, ncc_ram, ncc_mac, ncc_arith.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------------
//  in_chan   | in        | valid/ready        | x_sample, y_sample, last_sample
//  out_chan  | out       | valid/ready        | lag, coefficient, last_result
//  cfg_*     | in        | APB, pready high   | lag bound at byte address 0
//
// Samples load one pair a cycle into two RAMs. The pair flagged last closes the
// block; the sequencer then sweeps the RAMs for the energy sums, multiplies them
// into the energy product and takes its root. Each lag then takes a setup step,
// a MAC pass over the RAMs' read ports, two shift-add multiplies, the restoring
// divide and an emit step; lags without overlap, and every lag when the root is
// zero, go from setup straight to emit. The multiplies, the root and the divide
// share one iterative arithmetic unit. in_chan is ready only while loading. One
// result register holds each coefficient until its transfer; the next lag
// computes meanwhile and stalls at emit. Reset (synchronous, rst_n low) empties
// the sample count and sets the lag bound to 16; RAM contents are undefined
// until written and never read before then.
`default_nettype none
module normalized_cross_correlation #(
  parameter int MAX_SAMPLES = ncc_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_LAGS    = ncc_pkg::MAX_LAGS_DEF,
  parameter int SAMPLE_BITS = ncc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ncc_in_if.sink                                 in_chan,
  ncc_out_if.source                              out_chan,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [ncc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [ncc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output      logic [ncc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output      logic                              cfg_pready
);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int Q_PLUS = ncc_pkg::Q_W + 1;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_SAMPLES);
  localparam logic [ncc_pkg::LAGS_W-1:0] LAG_CAP = ncc_pkg::LAGS_W'(MAX_LAGS);
  localparam logic [Q_PLUS-1:0] LIM_POS = Q_PLUS'(33'h7FFF_FFFF);
  localparam logic [Q_PLUS-1:0] LIM_NEG = Q_PLUS'(33'h8000_0000);

  ncc_pkg::ncc_state_t state_r, state_nxt;

  // config
  logic [ncc_pkg::LAGS_W-1:0] lag_bound_r;
  logic [ncc_pkg::LAGS_W-1:0] lag_lim;
  logic                       cfg_wr;

  // sequencer datapath
  logic [CNT_W-1:0]               cnt_r, i_r, len;
  logic signed [ncc_pkg::LAG_W-1:0] m_r;
  logic [ncc_pkg::LAGS_W-1:0]     k;
  logic                           m_final;
  logic                           rd_vld_r;
  logic [ncc_pkg::ROOT_W-1:0]     root_r;
  logic [ncc_pkg::WIDE_W-1:0]     num_r;
  logic [ncc_pkg::ACC_W-1:0]      den_r, mag_r;
  logic                           neg_r;
  logic [ncc_pkg::COEF_W-1:0]     coef_r;

  // result register
  logic                           out_vld_r, out_last_r;
  logic signed [ncc_pkg::LAG_W-1:0] out_lag_r;
  logic [ncc_pkg::COEF_W-1:0]     out_coef_r;
  logic                           emit_go;

  // memories and units
  logic                           in_xfer, wr_en, rd_en, corr_mode;
  logic [AW-1:0]                  x_raddr, y_raddr;
  logic [SAMPLE_BITS-1:0]         x_rdata, y_rdata;
  logic                           mac_clr, mac_busy;
  logic [ncc_pkg::ACC_W-1:0]      sum0, sum1;
  ncc_pkg::ncc_arith_req_t        arith_req;
  ncc_pkg::ncc_arith_stat_t       arith_stat;
  logic [ncc_pkg::WIDE_W-1:0]     arith_a, arith_res;
  logic [ncc_pkg::ACC_W-1:0]      arith_b, arith_rem;
  logic                           arith_big;

  // rounding and saturation
  logic [Q_PLUS-1:0]              q_rnd, q_lim, q_sat;
  logic [ncc_pkg::COEF_W-1:0]     coef_nxt;
  logic                           skip_lag;
  logic [CNT_W-1:0]               cnt_nxt;

  assign lag_lim  = (lag_bound_r > LAG_CAP) ? LAG_CAP : lag_bound_r;
  assign k        = ncc_pkg::LAGS_W'(m_r[ncc_pkg::LAG_W-1] ? -m_r : m_r);
  assign m_final  = (m_r == $signed({1'b0, lag_lim}));
  assign skip_lag = ({{(CNT_W > ncc_pkg::LAGS_W ? CNT_W - ncc_pkg::LAGS_W : 0){1'b0}}, k}
                     >= cnt_r) || (root_r == '0);
  assign len      = corr_mode ? (cnt_r - CNT_W'(k)) : cnt_r;
  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign wr_en    = in_xfer && (cnt_r < FULL_CNT);
  assign cnt_nxt  = wr_en ? cnt_r + 1'b1 : cnt_r;
  assign corr_mode = (state_r == ncc_pkg::S_CR_RD) || (state_r == ncc_pkg::S_CR_WAIT)
                  || (state_r == ncc_pkg::S_LAG);

  // APB: one register, writes and reads take effect in the access phase
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                   && (cfg_paddr[2] == ncc_pkg::REG_LAG_BOUND);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == ncc_pkg::REG_LAG_BOUND)
                    ? ncc_pkg::CFG_DATA_W'(lag_bound_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_bound_r <= ncc_pkg::LAG_BOUND_RESET;
    end else if (cfg_wr) begin
      lag_bound_r <= cfg_pwdata[ncc_pkg::LAGS_W-1:0];
    end
  end

  // Sample RAMs; the later sample of a pair is read at i+|m|
  ncc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_x_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_chan.x_sample),
    .re    (rd_en),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  ncc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_y_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_chan.y_sample),
    .re    (rd_en),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  ncc_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (mac_clr),
    .vld   (rd_vld_r),
    .a0    ($signed(x_rdata)),
    .b0    (corr_mode ? $signed(y_rdata) : $signed(x_rdata)),
    .a1    (corr_mode ? '0 : $signed(y_rdata)),
    .b1    (corr_mode ? '0 : $signed(y_rdata)),
    .busy  (mac_busy),
    .sum0  (sum0),
    .sum1  (sum1)
  );

  ncc_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .a     (arith_a),
    .b     (arith_b),
    .stat  (arith_stat),
    .res   (arith_res),
    .rem   (arith_rem),
    .big   (arith_big)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ncc_pkg::S_LOAD: begin
        if (in_xfer && in_chan.last_sample) begin
          state_nxt = ncc_pkg::S_EN_RD;
        end
      end
      ncc_pkg::S_EN_RD: begin
        if (i_r == len - 1'b1) begin
          state_nxt = ncc_pkg::S_EN_WAIT;
        end
      end
      ncc_pkg::S_EN_WAIT: begin
        if (!rd_vld_r && !mac_busy) begin
          state_nxt = ncc_pkg::S_PMUL_GO;
        end
      end
      ncc_pkg::S_PMUL_GO: state_nxt = ncc_pkg::S_PMUL_WT;
      ncc_pkg::S_PMUL_WT: begin
        if (arith_stat.done) begin
          state_nxt = ncc_pkg::S_SQRT_GO;
        end
      end
      ncc_pkg::S_SQRT_GO: state_nxt = ncc_pkg::S_SQRT_WT;
      ncc_pkg::S_SQRT_WT: begin
        if (arith_stat.done) begin
          state_nxt = ncc_pkg::S_LAG;
        end
      end
      ncc_pkg::S_LAG: begin
        state_nxt = skip_lag ? ncc_pkg::S_EMIT : ncc_pkg::S_CR_RD;
      end
      ncc_pkg::S_CR_RD: begin
        if (i_r == len - 1'b1) begin
          state_nxt = ncc_pkg::S_CR_WAIT;
        end
      end
      ncc_pkg::S_CR_WAIT: begin
        if (!rd_vld_r && !mac_busy) begin
          state_nxt = ncc_pkg::S_NUM_GO;
        end
      end
      ncc_pkg::S_NUM_GO: state_nxt = ncc_pkg::S_NUM_WT;
      ncc_pkg::S_NUM_WT: begin
        if (arith_stat.done) begin
          state_nxt = ncc_pkg::S_DEN_GO;
        end
      end
      ncc_pkg::S_DEN_GO: state_nxt = ncc_pkg::S_DEN_WT;
      ncc_pkg::S_DEN_WT: begin
        if (arith_stat.done) begin
          state_nxt = ncc_pkg::S_DIV_GO;
        end
      end
      ncc_pkg::S_DIV_GO: state_nxt = ncc_pkg::S_DIV_WT;
      ncc_pkg::S_DIV_WT: begin
        if (arith_stat.done) begin
          state_nxt = ncc_pkg::S_EMIT;
        end
      end
      ncc_pkg::S_EMIT: begin
        if (emit_go) begin
          state_nxt = m_final ? ncc_pkg::S_LOAD : ncc_pkg::S_LAG;
        end
      end
      default: state_nxt = ncc_pkg::S_LOAD;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_chan.ready  = 1'b0;
    rd_en          = 1'b0;
    mac_clr        = 1'b0;
    emit_go        = 1'b0;
    arith_req.start = 1'b0;
    arith_req.op   = ncc_pkg::OP_MUL;
    arith_a        = '0;
    arith_b        = '0;
    x_raddr        = i_r[AW-1:0];
    y_raddr        = i_r[AW-1:0];
    case (state_r)
      ncc_pkg::S_LOAD: begin
        in_chan.ready = 1'b1;
        mac_clr       = 1'b1;
      end
      ncc_pkg::S_EN_RD: begin
        rd_en = 1'b1;
      end
      ncc_pkg::S_PMUL_GO: begin
        arith_req.start = 1'b1;
        arith_req.op    = ncc_pkg::OP_MUL;
        arith_a         = ncc_pkg::WIDE_W'(sum0);
        arith_b         = sum1;
      end
      ncc_pkg::S_SQRT_GO: begin
        arith_req.start = 1'b1;
        arith_req.op    = ncc_pkg::OP_SQRT;
        arith_a         = num_r;
      end
      ncc_pkg::S_LAG: begin
        mac_clr = 1'b1;
      end
      ncc_pkg::S_CR_RD: begin
        rd_en = 1'b1;
        if (m_r[ncc_pkg::LAG_W-1]) begin
          x_raddr = AW'(i_r + CNT_W'(k));
        end else begin
          y_raddr = AW'(i_r + CNT_W'(k));
        end
      end
      ncc_pkg::S_NUM_GO: begin
        arith_req.start = 1'b1;
        arith_req.op    = ncc_pkg::OP_MUL;
        arith_a         = ncc_pkg::WIDE_W'(mag_r);
        arith_b         = ncc_pkg::ACC_W'(cnt_r);
      end
      ncc_pkg::S_DEN_GO: begin
        arith_req.start = 1'b1;
        arith_req.op    = ncc_pkg::OP_MUL;
        arith_a         = ncc_pkg::WIDE_W'(root_r);
        arith_b         = ncc_pkg::ACC_W'(cnt_r - CNT_W'(k));
      end
      ncc_pkg::S_DIV_GO: begin
        arith_req.start = 1'b1;
        arith_req.op    = ncc_pkg::OP_DIV;
        arith_a         = num_r;
        arith_b         = den_r;
      end
      ncc_pkg::S_EMIT: begin
        emit_go = !out_vld_r || out_chan.ready;
      end
      default: begin
      end
    endcase
  end

  // Round half away from zero on the magnitude, then saturate and apply sign
  always_comb begin
    q_rnd = {1'b0, arith_res[ncc_pkg::Q_W-1:0]}
          + Q_PLUS'(arith_rem >= (den_r - arith_rem));
    q_lim = neg_r ? LIM_NEG : LIM_POS;
    q_sat = (arith_big || (q_rnd > q_lim)) ? q_lim : q_rnd;
    coef_nxt = neg_r ? (ncc_pkg::COEF_W'(0) - q_sat[ncc_pkg::COEF_W-1:0])
                     : q_sat[ncc_pkg::COEF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ncc_pkg::S_LOAD;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (state_r == ncc_pkg::S_LOAD) begin
        cnt_r <= cnt_nxt;
      end else if (state_r == ncc_pkg::S_EMIT && emit_go && m_final) begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ncc_pkg::S_LOAD: begin
        i_r <= '0;
        m_r <= -$signed({1'b0, lag_lim});
      end
      ncc_pkg::S_EN_RD, ncc_pkg::S_CR_RD: begin
        i_r <= i_r + 1'b1;
      end
      ncc_pkg::S_PMUL_WT: begin
        if (arith_stat.done) begin
          num_r <= arith_res << ncc_pkg::P_SHIFT;
        end
      end
      ncc_pkg::S_SQRT_WT: begin
        if (arith_stat.done) begin
          root_r <= arith_res[ncc_pkg::ROOT_W-1:0];
        end
      end
      ncc_pkg::S_LAG: begin
        i_r    <= '0;
        coef_r <= '0;
      end
      ncc_pkg::S_CR_WAIT: begin
        neg_r <= sum0[ncc_pkg::ACC_W-1];
        mag_r <= sum0[ncc_pkg::ACC_W-1] ? (ncc_pkg::ACC_W'(0) - sum0) : sum0;
      end
      ncc_pkg::S_NUM_WT: begin
        if (arith_stat.done) begin
          num_r <= arith_res << ncc_pkg::NUM_SHIFT;
        end
      end
      ncc_pkg::S_DEN_WT: begin
        if (arith_stat.done) begin
          den_r <= arith_res[ncc_pkg::ACC_W-1:0];
        end
      end
      ncc_pkg::S_DIV_WT: begin
        if (arith_stat.done) begin
          coef_r <= coef_nxt;
        end
      end
      ncc_pkg::S_EMIT: begin
        if (emit_go) begin
          m_r <= m_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: load on emit, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit_go) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_lag_r  <= m_r;
      out_coef_r <= coef_r;
      out_last_r <= m_final;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.lag         = out_lag_r;
  assign out_chan.coefficient = $signed(out_coef_r);
  assign out_chan.last_result = out_last_r;

  // The sample count never passes the RAM depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("sample count beyond RAM depth");

  // The arithmetic unit is never restarted mid-operation
  a_arith_idle: assert property (@(posedge clk) disable iff (!rst_n)
    arith_req.start |-> !arith_stat.busy)
    else $error("arithmetic unit started while busy");

  // The final result of a block carries the clamped lag bound
  a_last_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_last_r) |-> (out_lag_r == $signed({1'b0, lag_lim})))
    else $error("last result at wrong lag");

  // No MAC traffic while loading samples
  a_mac_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ncc_pkg::S_LOAD) |-> (!rd_vld_r && !mac_busy))
    else $error("MAC active during load");

endmodule
`default_nettype wire

### tb/ncc_tb_scoreboard.sv
// Scoreboard for the normalized cross-correlation testbench: predicts the
// coefficients of every closed block of sample pairs and checks the results.
// Depends on ncc_pkg for the sample store depth and the lag register width.
class ncc_scoreboard;
  typedef struct {
    logic signed [5:0]  lag;
    logic signed [31:0] coef;
    logic               last;
  } coef_t;

  coef_t  coef_queue[$];
  longint x_mem[ncc_pkg::MAX_SAMPLES_DEF];
  longint y_mem[ncc_pkg::MAX_SAMPLES_DEF];
  int     pair_cnt;
  int     lag_limit;
  int     errors;
  int     blocks;
  int     results;

  function new();
    pair_cnt  = 0;
    lag_limit = 16;
    errors    = 0;
    blocks    = 0;
    results   = 0;
  endfunction

  function void set_lags(logic [ncc_pkg::LAGS_W-1:0] v);
    lag_limit = (v > ncc_pkg::MAX_LAGS_DEF) ? ncc_pkg::MAX_LAGS_DEF : v;
  endfunction

  function int pending();
    return coef_queue.size();
  endfunction

  // Store one pair; a closing pair yields the whole lag sweep.
  function void note_input(logic signed [15:0] x, logic signed [15:0] y, logic last);
    longint       sxx, syy, acc;
    logic [127:0] energy, num, quo, rem, lim;
    logic [63:0]  root, cand, mag, den;
    int           n, k;
    bit           neg;
    coef_t        c;
    if (pair_cnt < ncc_pkg::MAX_SAMPLES_DEF) begin
      x_mem[pair_cnt] = x;
      y_mem[pair_cnt] = y;
      pair_cnt++;
    end
    if (!last) return;
    n = pair_cnt;
    sxx = 0;
    syy = 0;
    for (int i = 0; i < n; i++) begin
      sxx += x_mem[i] * x_mem[i];
      syy += y_mem[i] * y_mem[i];
    end
    energy = (128'(unsigned'(sxx)) * 128'(unsigned'(syy))) << 24;
    root = 0;
    if (energy != 0) begin
      for (int b = 63; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (128'(cand) * 128'(cand) <= energy) root = cand;
      end
    end
    for (int m = -lag_limit; m <= lag_limit; m++) begin
      k = (m < 0) ? -m : m;
      c.lag  = m[5:0];
      c.coef = 0;
      c.last = (m == lag_limit);
      if (k < n && root != 0) begin
        acc = 0;
        for (int i = 0; i + k < n; i++)
          acc += (m >= 0) ? x_mem[i] * y_mem[i + k] : x_mem[i + k] * y_mem[i];
        neg = acc < 0;
        mag = neg ? -acc : acc;
        num = (128'(mag) * 128'(n)) << 28;
        den = 64'(n - k) * root;
        if (den != 0) begin
          quo = num / 128'(den);
          rem = num % 128'(den);
          lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
          if (rem >= 128'(den) - rem) quo++;
          if (quo > lim) quo = lim;
          c.coef = neg ? -quo[31:0] : quo[31:0];
        end
      end
      coef_queue.push_back(c);
    end
    pair_cnt = 0;
    blocks++;
  endfunction

  function void check_result(logic signed [5:0] lag, logic signed [31:0] coef, logic last);
    coef_t e;
    results++;
    if (coef_queue.size() == 0) begin
      $display("%0t: unexpected result lag=%0d coef=%0d last=%0b", $time, lag, coef, last);
      errors++;
      return;
    end
    e = coef_queue.pop_front();
    if (e.lag !== lag || e.coef !== coef || e.last !== last) begin
      $display("%0t: mismatch expected lag=%0d coef=%0d last=%0b, got lag=%0d coef=%0d last=%0b",
               $time, e.lag, e.coef, e.last, lag, coef, last);
      errors++;
    end
  endfunction
endclass

### tb/normalized_cross_correlation_tb.sv
// Top-level testbench of the normalized cross-correlation block: drives sample
// pairs and lag bound writes, checks every coefficient. Depends on ncc_pkg,
// ncc_if, the block's RTL and ncc_tb_scoreboard.sv.
module normalized_cross_correlation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } pair_t;

  localparam int IDLE_LIMIT = 20000;   // longest quiet stretch: a big lag plus the long hold
  localparam int LONG_HOLD  = 3000;
  localparam int RANDOM_PAIRS = 140;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [ncc_pkg::CFG_ADDR_W-1:0] cfg_paddr = 0;
  logic [ncc_pkg::CFG_DATA_W-1:0] cfg_pwdata = 0;
  logic [ncc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  ncc_in_if  in_if();
  ncc_out_if out_if();

  normalized_cross_correlation uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  ncc_scoreboard sb = new();
  pair_t pair_queue[$];
  int    idle_cycles = 0;
  int    random_pairs = 0;
  int    long_hold_req = 0;
  bit    lags_seen[32];

  always #5 clk = ~clk;

  initial begin
    in_if.valid       <= 0;
    in_if.x_sample    <= 0;
    in_if.y_sample    <= 0;
    in_if.last_sample <= 0;
    out_if.ready      <= 0;
  end

  // Receiver: check each result transfer, stall on a pattern of its own, and
  // hold off for a long stretch when asked so the block backs up.
  initial begin : receiver
    int hold_left, mode, phase;
    hold_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.lag, out_if.coefficient, out_if.last_result);
      if (long_hold_req != 0) begin
        hold_left = long_hold_req;
        long_hold_req = 0;
      end
      phase++;
      if ((phase % 200) == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 0;
      end else begin
        case (mode)
          0: out_if.ready <= 1;                              // no stalls
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          2: out_if.ready <= ($urandom_range(0, 1) != 0);
          default: out_if.ready <= ((phase % 7) < 3);      // periodic stall
        endcase
      end
    end
  end

  // Watchdog: count cycles without any transfer on either channel.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send the queued pairs in bursts of random length with random gaps; never
  // drop valid while a pair waits for its transfer.
  task automatic send_pairs();
    int idx, burst, gap;
    bit offer;
    idx = 0;
    burst = $urandom_range(1, 12);
    gap = 0;
    while (idx < pair_queue.size()) begin
      @(posedge clk);
      if (in_if.valid && in_if.ready) begin
        sb.note_input(pair_queue[idx].x, pair_queue[idx].y, pair_queue[idx].last);
        idx++;
      end
      if (in_if.valid && !in_if.ready) offer = 1;
      else if (gap > 0) begin
        gap--;
        offer = 0;
      end else begin
        offer = 1;
        if (--burst == 0) begin
          burst = $urandom_range(1, 12);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (offer && idx < pair_queue.size()) begin
        in_if.valid       <= 1;
        in_if.x_sample    <= pair_queue[idx].x;
        in_if.y_sample    <= pair_queue[idx].y;
        in_if.last_sample <= pair_queue[idx].last;
      end else begin
        in_if.valid <= 0;
      end
    end
    pair_queue.delete();
  endtask

  // Hold until every expected coefficient has arrived, then let the block settle.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_lags(logic [4:0] v);
    @(posedge clk);
    cfg_psel    <= 1;
    cfg_pwrite  <= 1;
    cfg_penable <= 0;
    cfg_paddr   <= {ncc_pkg::REG_LAG_BOUND, 2'b00};
    cfg_pwdata  <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cfg_pwrite  <= 0;
    sb.set_lags(v);
    lags_seen[v] = 1;
  endtask

  function automatic logic signed [15:0] rand_sample(int kind);
    case (kind)
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Queue one block of n pairs; kind picks the sample flavor.
  task automatic add_block(int n, int kind);
    pair_t p;
    for (int i = 0; i < n; i++) begin
      p.x = (kind < 0) ? rand_sample(i % 4) : rand_sample(kind);
      p.y = (kind < 0) ? rand_sample((i + 1) % 4) : rand_sample(kind);
      p.last = (i == n - 1);
      pair_queue.push_back(p);
    end
  endtask

  initial begin : stimulus
    pair_t p;
    int n, lags_total;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    lags_seen[16] = 1;

    // Directed: single pair at the negative extreme, lags beyond the overlap.
    p.x = 16'sh8000; p.y = 16'sh8000; p.last = 1;
    pair_queue.push_back(p);
    // Zero energy in x.
    for (int i = 0; i < 3; i++) begin
      p.x = 0; p.y = 16'sh7fff; p.last = (i == 2);
      pair_queue.push_back(p);
    end
    add_block(4, -1);          // mixed extremes, bits of both signs
    add_block(3, 1);           // all max positive
    send_pairs();
    drain();

    write_lags(5'd0);
    add_block(3, 3);
    add_block(1, 0);
    send_pairs();
    drain();

    write_lags(5'd31);
    add_block(5, 3);
    send_pairs();
    drain();

    // Random phases: new lag bound each phase, small blocks with random content.
    for (int ph = 0; random_pairs < RANDOM_PAIRS; ph++) begin
      case (ph % 5)
        0: write_lags(5'd31);
        1: write_lags(5'd0);
        default: write_lags(5'($urandom_range(0, 31)));
      endcase
      for (int b = 0; b < 4; b++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        if (n > RANDOM_PAIRS - random_pairs) n = RANDOM_PAIRS - random_pairs;
        if (n > 0) begin
          add_block(n, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : 3);
          random_pairs += n;
        end
      end
      // Long hold-off on the first phase while the sender keeps offering pairs.
      if (ph == 0) long_hold_req = LONG_HOLD;
      send_pairs();
      drain();
    end

    lags_total = 0;
    foreach (lags_seen[i]) lags_total += lags_seen[i];
    $display("Covered %0d closed blocks, %0d coefficients, %0d lag bound settings.",
             sb.blocks, sb.results, lags_total);
    $display("Included zero energy, no overlap, extreme samples and a long output stall.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### files.f
rtl/ncc_pkg.sv
rtl/ncc_if.sv
rtl/ncc_ram.sv
rtl/ncc_mac.sv
rtl/ncc_arith.sv
rtl/normalized_cross_correlation.sv
tb/ncc_tb_scoreboard.sv
tb/normalized_cross_correlation_tb.sv
